// ===== sv/ifp_pkg.sv =====
// Shared types, constants and helpers of the IMU frame parser.
package ifp_pkg;

  localparam int unsigned PAYLOAD_BYTES = 18;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned IN_TDATA_W    = 8;
  localparam int unsigned OUT_TDATA_W   = 216;

  localparam logic [7:0] SYNC_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_MOTION = 8'h61;
  localparam logic [7:0] TYPE_REG    = 8'h71;
  localparam logic [7:0] REG_MAG     = 8'h3a;
  localparam logic [7:0] REG_BATT    = 8'h64;
  localparam logic [7:0] REG_TEMP    = 8'h40;
  localparam logic [7:0] REG_VER     = 8'h2e;

  localparam int unsigned N_LIMITS = 11;
  localparam logic signed [15:0] BATT_LIMIT [N_LIMITS] = '{
    16'sd396, 16'sd393, 16'sd387, 16'sd382, 16'sd379, 16'sd377,
    16'sd373, 16'sd370, 16'sd368, 16'sd350, 16'sd340
  };
  localparam logic [6:0] BATT_PCT [N_LIMITS] = '{
    7'd100, 7'd90, 7'd75, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd15, 7'd10, 7'd5
  };

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_SYNC,
    ST_COLLECT
  } ifp_state_e;

  typedef enum logic [2:0] {
    KIND_MOTION  = 3'd0,
    KIND_MAG     = 3'd1,
    KIND_BATT    = 3'd2,
    KIND_TEMP    = 3'd3,
    KIND_VER_SET = 3'd4,
    KIND_VER_CLR = 3'd5
  } ifp_kind_e;

  // One complete frame handed from the framer to the decoder.
  typedef struct packed {
    logic                                motion;
    logic [PAYLOAD_BYTES-1:0][7:0]       payload;
  } ifp_frame_t;

  // Result beat layout, lowest bits last in this list.
  typedef struct packed {
    logic [4:0]       pad;
    logic [31:0]      version_word;
    logic [8:0][15:0] value;
    logic [31:0]      frames_seen;
    ifp_kind_e        kind;
  } ifp_result_t;

  function automatic logic [6:0] batt_percent(logic signed [15:0] cv);
    logic [6:0] pct;
    pct = 7'd0;
    // lowest threshold first so higher ones take priority
    for (int i = N_LIMITS - 1; i >= 0; i--) begin
      if (cv > BATT_LIMIT[i]) pct = BATT_PCT[i];
    end
    return pct;
  endfunction

endpackage

// ===== sv/ifp_framer.sv =====
// Header hunt and payload collection, one byte per cycle when ready.
module ifp_framer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_valid_i,
  output logic                  byte_ready_o,
  input  logic [7:0]            byte_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output ifp_pkg::ifp_frame_t   push_frame_o
);
  import ifp_pkg::*;

  ifp_state_e                    state_q, state_d;
  logic [IDX_W-1:0]              idx_q, idx_d;
  logic                          motion_q, motion_d;
  logic [PAYLOAD_BYTES-1:0][7:0] payload_q;
  logic                          last_byte;
  logic                          fire;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  assign last_byte    = (state_q == ST_COLLECT) && (idx_q == LAST_IDX);
  assign byte_ready_o = !last_byte || push_ready_i;
  assign fire         = byte_valid_i && byte_ready_o;
  assign push_valid_o = fire && last_byte;

  assign push_frame_o.motion  = motion_q;
  assign push_frame_o.payload = {byte_i, payload_q[PAYLOAD_BYTES-1:1]};

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    motion_d = motion_q;
    if (fire) begin
      unique case (state_q)
        ST_HUNT: begin
          if (byte_i == SYNC_BYTE) state_d = ST_SYNC;
        end
        ST_SYNC: begin
          if (byte_i == TYPE_MOTION || byte_i == TYPE_REG) begin
            state_d  = ST_COLLECT;
            idx_d    = '0;
            motion_d = (byte_i == TYPE_MOTION);
          end else if (byte_i != SYNC_BYTE) begin
            state_d = ST_HUNT;
          end
        end
        ST_COLLECT: begin
          if (last_byte) begin
            state_d = ST_HUNT;
            idx_d   = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        default: state_d = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_HUNT;
      idx_q    <= '0;
      motion_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      motion_q <= motion_d;
    end
  end

  // payload shift line, newest byte at the top
  always_ff @(posedge clk_i) begin
    if (fire && state_q == ST_COLLECT) begin
      payload_q <= {byte_i, payload_q[PAYLOAD_BYTES-1:1]};
    end
  end

endmodule

// ===== sv/ifp_fifo.sv =====
// Short frame queue between framer and decoder.
module ifp_fifo #(
  parameter int unsigned Depth = ifp_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  ifp_pkg::ifp_frame_t push_frame_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output ifp_pkg::ifp_frame_t pop_frame_o
);
  import ifp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  ifp_frame_t      mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_frame_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_frame_i;
  end

endmodule

// ===== sv/ifp_decoder.sv =====
// Back end: frame decode, frame counter and output register.
module ifp_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 frame_valid_i,
  output logic                 frame_ready_o,
  input  ifp_pkg::ifp_frame_t  frame_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output ifp_pkg::ifp_result_t res_o
);
  import ifp_pkg::*;

  logic        out_valid_q;
  ifp_result_t out_q, res_d;
  logic [31:0] count_q;
  logic        known;
  logic        take;
  logic [7:0]  reg_byte;
  logic [8:0][15:0] words;
  logic [31:0] ver;

  assign frame_ready_o = !out_valid_q || res_ready_i;
  assign take          = frame_valid_i && frame_ready_o;
  assign res_valid_o   = out_valid_q;
  assign res_o         = out_q;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      words[k] = {frame_i.payload[2*k+1], frame_i.payload[2*k]};
    end
    reg_byte = frame_i.payload[0];
    ver      = {words[2], words[1]};
    known    = 1'b1;
    res_d    = '0;
    res_d.frames_seen = count_q + 32'd1;
    if (frame_i.motion) begin
      res_d.kind  = KIND_MOTION;
      res_d.value = words;
    end else begin
      unique case (reg_byte)
        REG_MAG: begin
          res_d.kind     = KIND_MAG;
          res_d.value[0] = words[1];
          res_d.value[1] = words[2];
          res_d.value[2] = words[3];
        end
        REG_BATT: begin
          res_d.kind     = KIND_BATT;
          res_d.value[0] = {9'd0, batt_percent(words[1])};
        end
        REG_TEMP: begin
          res_d.kind     = KIND_TEMP;
          res_d.value[0] = words[1];
        end
        REG_VER: begin
          res_d.kind         = ver[31] ? KIND_VER_SET : KIND_VER_CLR;
          res_d.version_word = ver;
        end
        default: known = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (take && known) begin
        out_valid_q <= 1'b1;
        count_q     <= count_q + 32'd1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && known) out_q <= res_d;
  end

endmodule

// ===== sv/imu_frame_parser_unit.sv =====
// Top level of the IMU frame parser: framer, frame queue and decoder.
//
//  channel  | dir | fields (tdata, lowest bit up)
//  ---------+-----+---------------------------------------------------------
//  s_axis   | in  | rx_byte[7:0]
//  m_axis   | out | kind[2:0], frames_seen[34:3], value_0..value_8 (16 each,
//           |     | from bit 35), version_word[210:179], zero pad to 216
//
// One byte beat is taken per cycle, except while the framer stalls as below. The
// framer never waits on the decoder except on the last byte of a frame when the
// frame queue is full. A frame is written into the queue and moves into the output
// register as it pops, which waits while the output register holds a stalled beat.
// The decoder decodes each frame combinationally; a frame is at least 20 beats long.
// rst_ni clears the hunt state, queue pointers, frame counter and output valid.
// A stalled output holds its beat while input bytes flow into the queue until the queue is full.
module imu_frame_parser_unit #(
  parameter int unsigned QueueDepth = ifp_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [ifp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [ifp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata    // kind, frames_seen,
                                                           // value_0..8, version_word
);
  import ifp_pkg::*;

  // framer -> queue
  logic        push_valid, push_ready;
  ifp_frame_t  push_frame;
  // queue -> decoder
  logic        pop_valid, pop_ready;
  ifp_frame_t  pop_frame;
  ifp_result_t result;

  ifp_framer u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_frame_o (push_frame)
  );

  ifp_fifo #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_frame_i (push_frame),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_frame_o  (pop_frame)
  );

  ifp_decoder u_decoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (pop_valid),
    .frame_ready_o (pop_ready),
    .frame_i       (pop_frame),
    .res_valid_o   (m_axis_tvalid),
    .res_ready_i   (m_axis_tready),
    .res_o         (result)
  );

  assign m_axis_tdata = result;

endmodule

// ===== sv/ifp_checker.sv =====
// Port-level checks of the IMU frame parser, bound to the top level.
module ifp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [ifp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ifp_pkg::*;

  ifp_result_t res;
  logic        seen_q;
  logic [31:0] last_q;
  logic        beat;

  assign res  = m_axis_tdata;
  assign beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      last_q <= '0;
    end else if (beat) begin
      seen_q <= 1'b1;
      last_q <= res.frames_seen;
    end
  end

  // frame count advances by one from beat to beat, starting at one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat |-> (res.frames_seen == (seen_q ? last_q + 32'd1 : 32'd1)))
    else $error("frame count did not advance by one");

  // non-motion beats carry zeros in value words 3, 5 and 8
  a_zero_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind != KIND_MOTION) |->
      (res.value[3] == '0 && res.value[8] == '0 && res.value[5] == '0))
    else $error("non-motion beat carries motion words");

  // battery percent stays in range; version kind matches bit 31 of the version word
  a_batt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.kind == KIND_BATT) |-> (res.value[0] <= 16'd100))
    else $error("battery percent out of range");

  a_ver_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res.kind == KIND_VER_SET || res.kind == KIND_VER_CLR)) |->
      (res.version_word[31] == (res.kind == KIND_VER_SET)))
    else $error("version kind disagrees with bit 31");

  // a stalled result beat stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

endmodule

bind imu_frame_parser_unit ifp_checker u_ifp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/imu_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the IMU frame parser: predicts decoded frames from input beats and compares results.
module imu_frame_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  input  logic                                s_axis_tready_i,
  input  logic [ifp_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,   // rx_byte
  input  logic                                m_axis_tvalid_i,
  input  logic                                m_axis_tready_i,
  input  logic [ifp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_i,   // kind, frames_seen,
                                                                // value_0..8, version_word
  output int unsigned                         fail_count_o,
  output int unsigned                         owed_count_o
);
  import ifp_pkg::*;

  // framer mirror
  logic                     sync_seen;
  logic                     collecting;
  logic [IDX_W-1:0]         body_idx;
  logic [7:0]               frame_kind_byte;
  logic [7:0]               body [PAYLOAD_BYTES];
  logic [31:0]              frame_count;

  ifp_result_t              decoded_frames_due [$];
  int unsigned              fails;
  int unsigned              owed;

  assign fail_count_o = fails;
  assign owed_count_o = owed;

  function automatic logic [15:0] charge_percent(logic signed [15:0] cv);
    if (cv > 16'sd396) return 16'd100;
    else if (cv > 16'sd393) return 16'd90;
    else if (cv > 16'sd387) return 16'd75;
    else if (cv > 16'sd382) return 16'd60;
    else if (cv > 16'sd379) return 16'd50;
    else if (cv > 16'sd377) return 16'd40;
    else if (cv > 16'sd373) return 16'd30;
    else if (cv > 16'sd370) return 16'd20;
    else if (cv > 16'sd368) return 16'd15;
    else if (cv > 16'sd350) return 16'd10;
    else if (cv > 16'sd340) return 16'd5;
    return 16'd0;
  endfunction

  // Decode the collected body; bumps the frame count only for known frames.
  function automatic bit decode_frame(output ifp_result_t r);
    logic [31:0] ver;
    r   = '0;
    ver = {body[5], body[4], body[3], body[2]};
    if (frame_kind_byte == TYPE_MOTION) begin
      r.kind = KIND_MOTION;
      for (int k = 0; k < 9; k++) r.value[k] = {body[2*k+1], body[2*k]};
    end else begin
      case (body[0])
        REG_MAG: begin
          r.kind     = KIND_MAG;
          r.value[0] = {body[3], body[2]};
          r.value[1] = {body[5], body[4]};
          r.value[2] = {body[7], body[6]};
        end
        REG_BATT: begin
          r.kind     = KIND_BATT;
          r.value[0] = charge_percent({body[3], body[2]});
        end
        REG_TEMP: begin
          r.kind     = KIND_TEMP;
          r.value[0] = {body[3], body[2]};
        end
        REG_VER: begin
          r.kind         = ver[31] ? KIND_VER_SET : KIND_VER_CLR;
          r.version_word = ver;
        end
        default: return 1'b0;
      endcase
    end
    frame_count   = frame_count + 32'd1;
    r.frames_seen = frame_count;
    return 1'b1;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    ifp_result_t res;
    if (!collecting) begin
      if (sync_seen && (b == TYPE_MOTION || b == TYPE_REG)) begin
        collecting      = 1'b1;
        frame_kind_byte = b;
        body_idx        = '0;
        sync_seen       = 1'b0;
      end else begin
        sync_seen = (b == SYNC_BYTE);
      end
    end else begin
      body[body_idx] = b;
      body_idx       = body_idx + 1'b1;
      if (body_idx == PAYLOAD_BYTES) begin
        collecting = 1'b0;
        body_idx   = '0;
        sync_seen  = 1'b0;
        if (decode_frame(res)) begin
          decoded_frames_due.push_back(res);
          owed++;
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_result(input ifp_result_t got);
    ifp_result_t want;
    if (decoded_frames_due.size() == 0) begin
      $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
      fails++;
      return;
    end
    want = decoded_frames_due.pop_front();
    owed--;
    compare_field("kind", 32'(want.kind), 32'(got.kind));
    compare_field("frames_seen", want.frames_seen, got.frames_seen);
    for (int k = 0; k < 9; k++)
      compare_field($sformatf("value_%0d", k), 32'(want.value[k]), 32'(got.value[k]));
    compare_field("version_word", want.version_word, got.version_word);
    compare_field("pad", 32'(want.pad), 32'(got.pad));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_seen       = 1'b0;
      collecting      = 1'b0;
      body_idx        = '0;
      frame_kind_byte = '0;
      frame_count     = '0;
      for (int k = 0; k < PAYLOAD_BYTES; k++) body[k] = '0;
      decoded_frames_due.delete();
      owed            = 0;
      fails           = 0;
    end else begin
      // the output is registered, so a beat never leaves in the cycle its byte enters
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(ifp_result_t'(m_axis_tdata_i));
      if (s_axis_tvalid_i && s_axis_tready_i) absorb_byte(s_axis_tdata_i);
    end
  end

endmodule

// ===== dv/tb_imu_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the IMU frame parser: byte stimulus, output back-pressure and verdict.
module tb_imu_frame_parser_unit;
  import ifp_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;   // long output hold-off
  localparam int unsigned QUIET_LIMIT  = 4000;  // cycles with no beat on either side
  localparam int unsigned PHASE_BYTES  = 75;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;      // rx_byte
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;           // kind, frames_seen, value_0..8,
                                                   // version_word, pad
  int unsigned             fail_count;
  int unsigned             owed_count;

  int unsigned             send_idle_pct = 0;
  int unsigned             recv_stall_pct = 0;
  bit                      hold_req = 1'b0;
  int unsigned             bytes_sent = 0;
  logic [7:0]              frame_body [PAYLOAD_BYTES];

  imu_frame_parser_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  imu_frame_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .owed_count_o    (owed_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stalls, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // One byte beat, with random idle cycles before it; returns at its accepting edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Stop offering and wait until every decoded frame has come out.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (owed_count != 0);
  endtask

  task automatic send_frame(input int unsigned syncs, input logic [7:0] ftype);
    repeat (syncs) send_byte(SYNC_BYTE);
    send_byte(ftype);
    for (int k = 0; k < PAYLOAD_BYTES; k++) send_byte(frame_body[k]);
  endtask

  task automatic fill_body_random();
    for (int k = 0; k < PAYLOAD_BYTES; k++) frame_body[k] = 8'($urandom);
  endtask

  // Register frame; word lands little-endian in body bytes 2..5.
  task automatic send_reg_frame(input logic [7:0] reg_code, input logic [31:0] word);
    fill_body_random();
    frame_body[0] = reg_code;
    frame_body[2] = word[7:0];
    frame_body[3] = word[15:8];
    frame_body[4] = word[23:16];
    frame_body[5] = word[31:24];
    send_frame(1, TYPE_REG);
  endtask

  task automatic send_directed();
    // motion frame with sign extremes, behind a doubled sync byte
    fill_body_random();
    frame_body[0] = 8'h00; frame_body[1] = 8'h80;
    frame_body[2] = 8'hff; frame_body[3] = 8'h7f;
    frame_body[4] = 8'h00; frame_body[5] = 8'h00;
    frame_body[6] = 8'hff; frame_body[7] = 8'hff;
    frame_body[8] = 8'h01; frame_body[9] = 8'h00;
    send_frame(2, TYPE_MOTION);
    // sync broken by a foreign byte, then lone type bytes: no frame
    send_byte(SYNC_BYTE);
    send_byte(8'h12);
    send_byte(TYPE_MOTION);
    send_byte(TYPE_REG);
    // header bytes inside a body are plain data
    for (int k = 0; k < PAYLOAD_BYTES; k++) frame_body[k] = k[0] ? TYPE_MOTION : SYNC_BYTE;
    send_frame(1, TYPE_MOTION);
    send_reg_frame(REG_MAG, $urandom);
    // battery: just above the top step, around the lowest step, most negative
    send_reg_frame(REG_BATT, 32'd397);
    send_reg_frame(REG_BATT, 32'd341);
    send_reg_frame(REG_BATT, 32'd340);
    send_reg_frame(REG_BATT, 32'h0000_8000);
    send_reg_frame(REG_TEMP, 32'h0000_ffff);
    send_reg_frame(REG_VER, 32'h8000_0000);
    send_reg_frame(REG_VER, 32'h7fff_ffff);
    // unknown register codes are dropped
    send_reg_frame(8'h00, $urandom);
    send_reg_frame(8'hff, $urandom);
  endtask

  task automatic send_random_chunk();
    int unsigned pick;
    logic [15:0] cv;
    pick = $urandom_range(99);
    if (pick < 72) begin
      repeat ($urandom_range(2)) send_byte(8'($urandom));
      if ($urandom_range(2) == 0) begin
        fill_body_random();
        send_frame(1 + $urandom_range(1), TYPE_MOTION);
      end else begin
        case ($urandom_range(5))
          0: send_reg_frame(REG_MAG, $urandom);
          1, 2: begin
            // mostly right around a battery step, sometimes anywhere
            if ($urandom_range(3) != 0)
              cv = 16'(int'(BATT_LIMIT[$urandom_range(N_LIMITS - 1)])
                       + int'($urandom_range(2)) - 1);
            else
              cv = 16'($urandom);
            send_reg_frame(REG_BATT, {16'($urandom), cv});
          end
          3: send_reg_frame(REG_TEMP, $urandom);
          4: send_reg_frame(REG_VER, $urandom);
          default: send_reg_frame(8'($urandom), $urandom);
        endcase
      end
    end else if (pick < 86) begin
      repeat ($urandom_range(8, 1)) send_byte(8'($urandom));
    end else if (pick < 93) begin
      send_byte(SYNC_BYTE);
      send_byte(8'($urandom));
    end else begin
      send_byte($urandom_range(1) ? TYPE_MOTION : TYPE_REG);
    end
  endtask

  initial begin
    int unsigned phase_start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (ph == 0) begin
        send_directed();
        wait_for_results();
        // hold the output off while frames keep coming, so the input backs up
        hold_req = 1'b1;
        repeat (8) begin
          fill_body_random();
          send_frame(1, TYPE_MOTION);
        end
        wait_for_results();
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_random_chunk();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && owed_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== imu_frame_parser_unit.f =====
sv/ifp_pkg.sv
sv/ifp_framer.sv
sv/ifp_fifo.sv
sv/ifp_decoder.sv
sv/imu_frame_parser_unit.sv
sv/ifp_checker.sv
dv/imu_frame_checker.sv
dv/tb_imu_frame_parser_unit.sv
